// ----- hw/rtl/gbp_pkg.sv -----
// Shared types, op codes and default sizes for the gshare branch predictor.
`timescale 1ns / 1ps

package gbp_pkg;

   // Default sizes, handed to the top level as parameter defaults
   localparam int TABLE_ENTRIES_DEF = 4096;
   localparam int COUNTER_BITS_DEF  = 2;
   localparam int HISTORY_BITS_DEF  = 12;
   localparam int THREADS_DEF       = 4;

   // Fixed field widths
   localparam int OP_W     = 3;
   localparam int THREAD_W = 2;
   localparam int PC_W     = 30;
   localparam int CKPT_W   = 12;
   // Width that holds any history, any pc and any table index
   localparam int KEY_W    = 32;

   // Op codes
   localparam logic [OP_W-1:0] OP_LOOKUP  = 3'd0;
   localparam logic [OP_W-1:0] OP_UNCOND  = 3'd1;
   localparam logic [OP_W-1:0] OP_BTBMISS = 3'd2;
   localparam logic [OP_W-1:0] OP_RESOLVE = 3'd3;
   localparam logic [OP_W-1:0] OP_SQUASH  = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [THREAD_W-1:0] thread;
      logic [PC_W-1:0]     pc;
      logic                taken;
      logic                squashed;
      logic [CKPT_W-1:0]   restore_history;
   } gbp_req_type;

   typedef struct packed {
      logic              predict_taken;
      logic [CKPT_W-1:0] checkpoint_history;
   } gbp_rsp_type;

endpackage

// ----- hw/rtl/gbp_table.sv -----
// Saturating counter table: RAM with a registered read port and a clearing pass after reset.
`timescale 1ns / 1ps

module gbp_table #(
   parameter int ENTRIES      = gbp_pkg::TABLE_ENTRIES_DEF,
   parameter int COUNTER_BITS = gbp_pkg::COUNTER_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [$clog2(ENTRIES)-1:0]  rd_addr,
   output logic [COUNTER_BITS-1:0]     rd_data,
   input  logic                        wr_en,
   input  logic [$clog2(ENTRIES)-1:0]  wr_addr,
   input  logic [COUNTER_BITS-1:0]     wr_data,
   output logic                        busy
);
   import gbp_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);

   logic [COUNTER_BITS-1:0] mem [ENTRIES];
   logic [COUNTER_BITS-1:0] rd_data_ff;
   logic                    clr_busy_ff, clr_busy_in;
   logic [IDX_W-1:0]        clr_addr_ff, clr_addr_in;

   // Sweep every entry to zero, one per cycle
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + IDX_W'(1);
         if (clr_addr_ff == {IDX_W{1'b1}}) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Write port: the clearing pass owns it while busy
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_busy_ff;

endmodule

// ----- hw/rtl/gshare_branch_predictor.sv -----
// Top level of the gshare branch predictor: history registers, control and result register.
`timescale 1ns / 1ps

// Gshare predictor with one global history register per hardware thread and a
// shared table of saturating counters, indexed by history XOR branch word address
// (resolve uses the returned checkpoint instead of the live history). The transfer
// cycle issues the counter RAM read; in ST_MEM the item uses the read data, updates
// the history or writes the counter back, and loads the result register; the
// registered read port of the counter RAM is why the item goes on to ST_MEM.
// Lookup and unconditional ops on a valid thread give one result each, other ops
// none. The result register lets a new item start while a result waits; an item
// with a result stalls in ST_MEM only if the previous result is still untaken.
// After reset the counter table is cleared one entry per cycle, so no item is
// taken until the clearing pass is over.
module gshare_branch_predictor #(
   parameter int TABLE_ENTRIES = gbp_pkg::TABLE_ENTRIES_DEF,
   parameter int COUNTER_BITS  = gbp_pkg::COUNTER_BITS_DEF,
   parameter int HISTORY_BITS  = gbp_pkg::HISTORY_BITS_DEF,
   parameter int THREADS       = gbp_pkg::THREADS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  gbp_pkg::gbp_req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output gbp_pkg::gbp_rsp_type rsp_data
);
   import gbp_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int THR_W = (THREADS > 1) ? $clog2(THREADS) : 1;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_MEM  = 1'b1;

   logic                    state_ff, state_in;
   logic [HISTORY_BITS-1:0] history_ff [THREADS];
   logic [HISTORY_BITS-1:0] history_in [THREADS];
   gbp_req_type             item_ff;
   logic [THR_W-1:0]        thr_ff;
   logic                    thr_ok_ff;
   logic [IDX_W-1:0]        idx_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   gbp_rsp_type             rsp_data_ff, rsp_data_in;

   logic                    accept;
   logic [THR_W-1:0]        thr_sel;
   logic                    thr_ok;
   logic [HISTORY_BITS-1:0] cur_hist;
   logic [KEY_W-1:0]        key;
   logic [IDX_W-1:0]        rd_addr;
   logic [COUNTER_BITS-1:0] ctr;
   logic                    tbl_busy;
   logic                    wr_en;
   logic [COUNTER_BITS-1:0] wr_data;
   logic [HISTORY_BITS-1:0] hist_q;
   logic                    needs_rsp;
   logic                    done;
   logic                    pred;

   // Counter RAM
   gbp_table #(
      .ENTRIES      (TABLE_ENTRIES),
      .COUNTER_BITS (COUNTER_BITS)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (ctr),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (wr_data),
      .busy    (tbl_busy)
   );

   // Take an item only when idle and the table is cleared
   assign req_ready = (state_ff == ST_IDLE) && !tbl_busy;
   assign accept    = req_valid && req_ready;

   // Form the table index at transfer time
   always_comb begin
      thr_sel  = THR_W'(req_data.thread);
      thr_ok   = int'(req_data.thread) < THREADS;
      cur_hist = thr_ok ? history_ff[thr_sel] : '0;
      if (req_data.op == OP_RESOLVE) begin
         key = KEY_W'(req_data.restore_history) ^ KEY_W'(req_data.pc);
      end else begin
         key = KEY_W'(cur_hist) ^ KEY_W'(req_data.pc);
      end
      rd_addr = key[IDX_W-1:0];
   end

   // In ST_MEM: use the counter, hold a result item while the result register stays full
   always_comb begin
      hist_q    = thr_ok_ff ? history_ff[thr_ff] : '0;
      needs_rsp = thr_ok_ff && ((item_ff.op == OP_LOOKUP) || (item_ff.op == OP_UNCOND));
      done      = !(needs_rsp && rsp_valid_ff && !rsp_ready);
      pred      = (item_ff.op == OP_UNCOND) ? 1'b1 : ctr[COUNTER_BITS-1];
   end

   // Saturating counter update for an unsquashed resolve
   always_comb begin
      wr_en = (state_ff == ST_MEM) && thr_ok_ff && (item_ff.op == OP_RESOLVE) &&
              !item_ff.squashed;
      if (item_ff.taken) begin
         wr_data = (ctr == {COUNTER_BITS{1'b1}}) ? ctr : ctr + COUNTER_BITS'(1);
      end else begin
         wr_data = (ctr == '0) ? ctr : ctr - COUNTER_BITS'(1);
      end
   end

   // History update
   always_comb begin
      history_in = history_ff;
      if ((state_ff == ST_MEM) && done && thr_ok_ff) begin
         case (item_ff.op)
            OP_LOOKUP: begin
               history_in[thr_ff] = HISTORY_BITS'({hist_q, pred});
            end
            OP_UNCOND: begin
               history_in[thr_ff] = HISTORY_BITS'({hist_q, 1'b1});
            end
            OP_BTBMISS: begin
               history_in[thr_ff] = {hist_q[HISTORY_BITS-1:1], 1'b0};
            end
            OP_RESOLVE: begin
               if (item_ff.squashed) begin
                  history_in[thr_ff] =
                     HISTORY_BITS'({KEY_W'(item_ff.restore_history), item_ff.taken});
               end
            end
            OP_SQUASH: begin
               history_in[thr_ff] = HISTORY_BITS'(item_ff.restore_history);
            end
            default: begin
               history_in[thr_ff] = hist_q;
            end
         endcase
      end
   end

   // Result register: drop on transfer, load on a finished lookup or unconditional op
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == ST_MEM) && done && needs_rsp) begin
         rsp_valid_in                   = 1'b1;
         rsp_data_in.predict_taken      = pred;
         rsp_data_in.checkpoint_history = CKPT_W'(hist_q);
      end
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MEM;
            end
         end
         ST_MEM: begin
            if (done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < THREADS; i++) begin
            history_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         history_ff   <= history_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         item_ff   <= req_data;
         thr_ff    <= thr_sel;
         thr_ok_ff <= thr_ok;
         idx_ff    <= rd_addr;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- bench/gshare_result_checker.sv -----
// Result checker for the gshare branch predictor: tracks predictor state and compares results.
`timescale 1ns / 1ps

module gshare_result_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  gbp_pkg::gbp_req_type req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  gbp_pkg::gbp_rsp_type rsp_data,
   output int                   mismatches,
   output int                   outstanding
);
   import gbp_pkg::*;

   localparam int IDX_W  = $clog2(TABLE_ENTRIES_DEF);
   localparam int HIST_W = HISTORY_BITS_DEF;
   localparam int CTR_W  = COUNTER_BITS_DEF;
   localparam logic [CTR_W-1:0] CTR_MAX  = '1;
   localparam logic [CTR_W-1:0] CTR_HALF = CTR_W'((1 << (CTR_W - 1)) - 1);

   // Shadow copy of the counter table and the per-thread history registers
   logic [CTR_W-1:0]  ctr_table   [TABLE_ENTRIES_DEF];
   logic [HIST_W-1:0] thread_hist [THREADS_DEF];

   // Predictions not yet matched by a result transfer, oldest first
   gbp_rsp_type predicted_rsp_q [$];

   // Apply one accepted request to the shadow state; return 1 when it yields a result
   function automatic bit apply_request(input gbp_req_type item, output gbp_rsp_type rsp);
      logic [HIST_W-1:0] hist;
      logic [KEY_W-1:0]  key;
      logic [IDX_W-1:0]  idx;
      logic              guess;
      rsp = '0;
      if (int'(item.thread) >= THREADS_DEF) return 1'b0;
      hist = thread_hist[item.thread];
      case (item.op)
         OP_LOOKUP, OP_UNCOND: begin
            key   = KEY_W'(hist) ^ KEY_W'(item.pc);
            idx   = key[IDX_W-1:0];
            guess = (item.op == OP_UNCOND) ? 1'b1 : (ctr_table[idx] > CTR_HALF);
            rsp.predict_taken      = guess;
            rsp.checkpoint_history = CKPT_W'(hist);
            thread_hist[item.thread] = {hist[HIST_W-2:0], guess};
            return 1'b1;
         end
         OP_BTBMISS: begin
            thread_hist[item.thread][0] = 1'b0;
         end
         OP_RESOLVE: begin
            if (item.squashed) begin
               // mispredict: rebuild history from the checkpoint and the real outcome
               thread_hist[item.thread] = HIST_W'({item.restore_history, item.taken});
            end else begin
               // train the counter addressed by the checkpoint, saturating both ways
               key = KEY_W'(item.restore_history) ^ KEY_W'(item.pc);
               idx = key[IDX_W-1:0];
               if (item.taken && ctr_table[idx] != CTR_MAX)
                  ctr_table[idx] = ctr_table[idx] + 1'b1;
               else if (!item.taken && ctr_table[idx] != '0)
                  ctr_table[idx] = ctr_table[idx] - 1'b1;
            end
         end
         OP_SQUASH: begin
            thread_hist[item.thread] = HIST_W'(item.restore_history);
         end
         default: begin
         end
      endcase
      return 1'b0;
   endfunction

   // Compare result transfers first, then record predictions for request transfers
   always @(posedge clock) begin
      gbp_rsp_type want;
      gbp_rsp_type got;
      if (reset) begin
         foreach (ctr_table[i]) ctr_table[i] = '0;
         foreach (thread_hist[i]) thread_hist[i] = '0;
         predicted_rsp_q.delete();
         mismatches = 0;
         outstanding <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (predicted_rsp_q.size() == 0) begin
               $display("%0t: unexpected result: expected none, got taken=%0b ckpt=%03h",
                        $time, got.predict_taken, got.checkpoint_history);
               mismatches++;
            end else begin
               want = predicted_rsp_q.pop_front();
               if (got.predict_taken !== want.predict_taken) begin
                  $display("%0t: predict_taken mismatch: expected %0b, got %0b",
                           $time, want.predict_taken, got.predict_taken);
                  mismatches++;
               end
               if (got.checkpoint_history !== want.checkpoint_history) begin
                  $display("%0t: checkpoint_history mismatch: expected %03h, got %03h",
                           $time, want.checkpoint_history, got.checkpoint_history);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (apply_request(req_data, want)) predicted_rsp_q.push_back(want);
         end
         outstanding <= predicted_rsp_q.size();
      end
   end

endmodule

// ----- bench/gshare_branch_predictor_tb.sv -----
// Testbench top for the gshare branch predictor: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module gshare_branch_predictor_tb;
   import gbp_pkg::*;

   localparam int RANDOM_ITEMS = 700;
   localparam int TRAIN_SLOTS  = 8;
   localparam int IDX_W        = $clog2(TABLE_ENTRIES_DEF);
   localparam int PC_HI_W      = PC_W - IDX_W;
   localparam logic [OP_W-1:0] OP_RSVD_LO = OP_SQUASH + 1'b1;
   localparam logic [OP_W-1:0] OP_RSVD_HI = '1;

   typedef enum logic [1:0] {STALL_NONE, STALL_SHORT, STALL_LONG} stall_mode_type;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   gbp_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   gbp_rsp_type rsp_data;
   int          mismatches;
   int          outstanding;

   int             burst_left = 0;
   int             items_sent = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left  = 0;
   int             stall_left = 0;

   // Counter indexes that episodes keep training, each with a preferred outcome
   logic [IDX_W-1:0] slot_index [TRAIN_SLOTS];
   bit               slot_bias  [TRAIN_SLOTS];

   gshare_branch_predictor dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   gshare_result_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always #5 clock = ~clock;

   function automatic gbp_req_type make_req(input logic [OP_W-1:0] op,
                                            input logic [THREAD_W-1:0] thr,
                                            input logic [PC_W-1:0] pc,
                                            input logic taken,
                                            input logic squashed,
                                            input logic [CKPT_W-1:0] restore);
      return {op, thr, pc, taken, squashed, restore};
   endfunction

   // Drive one request and hold it until the transfer; idle between bursts
   task automatic send_req(input gbp_req_type item);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 200)
                                                  : $urandom_range(1, 16);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      if (item.op <= OP_SQUASH) items_sent++;
   endtask

   // Result-side backpressure: switch between no stalls, short and long stalls
   always @(posedge clock) begin
      if (mode_left == 0) begin
         mode_left  <= $urandom_range(32, 256);
         stall_mode <= stall_mode_type'($urandom_range(0, 2));
      end else begin
         mode_left <= mode_left - 1;
      end
      if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stall_mode == STALL_SHORT && $urandom_range(0, 2) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 2);
      end else if (stall_mode == STALL_LONG && $urandom_range(0, 7) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(4, 19);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Stimulus and verdict
   initial begin
      int                  stop_at;
      int                  k;
      logic [THREAD_W-1:0] t;
      logic [PC_W-1:0]     pc;
      logic [CKPT_W-1:0]   hist;
      logic                outcome;

      foreach (slot_index[i]) begin
         slot_index[i] = IDX_W'($urandom);
         slot_bias[i]  = 1'($urandom_range(0, 1));
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: cold lookups at both pc extremes
      send_req(make_req(OP_LOOKUP, 2'd0, '0, 1'b0, 1'b0, '0));
      send_req(make_req(OP_LOOKUP, 2'd3, '1, 1'b1, 1'b1, '1));
      // unconditional shifts in ones, btb miss clears the newest bit
      send_req(make_req(OP_UNCOND, 2'd1, '0, 1'b0, 1'b0, '0));
      send_req(make_req(OP_UNCOND, 2'd1, '1, 1'b0, 1'b0, '0));
      send_req(make_req(OP_BTBMISS, 2'd1, '0, 1'b1, 1'b0, '1));
      send_req(make_req(OP_UNCOND, 2'd1, '0, 1'b0, 1'b0, '0));
      // saturate one counter at the top, then see it predict taken
      repeat (4) send_req(make_req(OP_RESOLVE, 2'd2, {{PC_HI_W{1'b1}}, {IDX_W{1'b0}}},
                                   1'b1, 1'b0, '1));
      send_req(make_req(OP_SQUASH, 2'd2, '0, 1'b0, 1'b0, '1));
      send_req(make_req(OP_LOOKUP, 2'd2, {{PC_HI_W{1'b1}}, {IDX_W{1'b0}}}, 1'b0, 1'b0, '0));
      // drive it past the bottom
      repeat (4) send_req(make_req(OP_RESOLVE, 2'd2, {{PC_HI_W{1'b1}}, {IDX_W{1'b0}}},
                                   1'b0, 1'b0, '1));
      // mispredict rebuild, then a lookup that shows the rebuilt history
      send_req(make_req(OP_RESOLVE, 2'd2, '1, 1'b1, 1'b1, '0));
      send_req(make_req(OP_LOOKUP, 2'd2, '0, 1'b0, 1'b0, '0));
      // unused op codes with every field high are dropped
      for (int op = OP_RSVD_LO; op <= OP_RSVD_HI; op++)
         send_req(make_req(OP_W'(op), '1, '1, 1'b1, 1'b1, '1));

      // Random: mostly train-and-check episodes, some noise
      stop_at = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 99) < 80) begin
            t    = THREAD_W'($urandom);
            k    = $urandom_range(0, TRAIN_SLOTS - 1);
            pc   = PC_W'($urandom);
            hist = CKPT_W'(pc) ^ CKPT_W'(slot_index[k]);
            if ($urandom_range(0, 15) == 0) slot_bias[k] = !slot_bias[k];
            // pin the history so the lookup lands on a trained counter
            send_req(make_req(OP_SQUASH, t, PC_W'($urandom), 1'($urandom), 1'($urandom), hist));
            if ($urandom_range(0, 3) == 0)
               send_req(make_req($urandom_range(0, 1) ? OP_UNCOND : OP_BTBMISS, t + 1'b1,
                                 PC_W'($urandom), 1'($urandom), 1'($urandom),
                                 CKPT_W'($urandom)));
            send_req(make_req(OP_LOOKUP, t, pc, 1'($urandom), 1'($urandom), CKPT_W'($urandom)));
            repeat ($urandom_range(1, 3)) begin
               outcome = slot_bias[k] ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 4) == 0);
               send_req(make_req(OP_RESOLVE, t, {PC_HI_W'($urandom), pc[IDX_W-1:0]},
                                 outcome, 1'b0, hist));
            end
            if ($urandom_range(0, 3) == 0)
               send_req(make_req(OP_RESOLVE, t, PC_W'($urandom), 1'($urandom), 1'b1, hist));
         end else begin
            send_req(make_req(($urandom_range(0, 9) == 0)
                                 ? OP_W'($urandom_range(OP_RSVD_LO, OP_RSVD_HI))
                                 : OP_W'($urandom_range(OP_LOOKUP, OP_SQUASH)),
                              THREAD_W'($urandom), PC_W'($urandom), 1'($urandom),
                              1'($urandom), CKPT_W'($urandom)));
         end
      end
      req_valid <= 1'b0;

      // Drain outstanding results, then let the last non-result items settle
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Hard stop if the handshakes hang
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
